>>> rtl/core/random_access_deque_core_assert.svh
// Assertion macros shared by the random access deque core.
// Users must have signals named clk and rst_n in scope.
`ifndef RANDOM_ACCESS_DEQUE_CORE_ASSERT_SVH
`define RANDOM_ACCESS_DEQUE_CORE_ASSERT_SVH

// Checks that a condition holds on every clock edge outside reset.
`define RAD_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("deque core assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define RAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core assertion failed");

`endif

>>> rtl/core/rad_pkg.sv
// Package for the random access deque core: sizes, codes and shared types.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps

package rad_pkg;

    localparam int DEPTH       = 1024;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int SUM_W       = ADDR_W + 1;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 10;
    localparam int MODE_W      = 2;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = 11;
    localparam int CMP_W       = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - WORD_W - STAT_W - CNT_W;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    localparam logic SIDE_FRONT = 1'b0;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } rad_cmd_t;

    function automatic logic [ADDR_W-1:0] wrap_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] ofs
    );
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/core/rad_ctrl.sv
// Controller of the random access deque core: sequences capture, execute
// and result load, and owns both stream handshakes. Depends on rad_pkg.
`timescale 1ns / 1ps

module rad_ctrl
    import rad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output rad_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        s_tready    = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/rad_datapath.sv
// Datapath of the random access deque core: circular word store, head and
// fill registers, and the result register. Depends on rad_pkg and the
// assertion macro header.
`timescale 1ns / 1ps
`include "random_access_deque_core_assert.svh"

module rad_datapath
    import rad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rad_cmd_t          cmd,
    input  logic [MODE_W-1:0] in_mode,
    input  logic              in_side,
    input  logic [WORD_W-1:0] in_value,
    input  logic [POS_W-1:0]  in_position,
    output logic [WORD_W-1:0] out_word,
    output logic [STAT_W-1:0] out_status,
    output logic [CNT_W-1:0]  out_count
);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [MODE_W-1:0] mode_reg;
    logic              side_reg;
    logic [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    status_t           stat_reg;
    status_t           stat_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic [WORD_W-1:0] q_reg;

    logic [WORD_W-1:0] out_word_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              full;
    logic              empty;
    logic              in_range;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign in_range = (CMP_W'(pos_reg) < CMP_W'(fill_reg));
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        stat_next  = stat_reg;
        rd_ok_next = rd_ok_reg;
        mem_we     = 1'b0;
        mem_addr   = wrap_add(head_reg, ADDR_W'(pos_reg));
        if (cmd.exec)
        begin
            stat_next  = STAT_OK;
            rd_ok_next = 1'b0;
            case (mode_reg)
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (side_reg == SIDE_FRONT)
                        begin
                            head_next = head_dec;
                            mem_addr  = head_dec;
                        end
                        else
                        begin
                            mem_addr = wrap_add(head_reg, ADDR_W'(fill_reg));
                        end
                    end
                end
                MODE_READ:
                begin
                    if (!in_range)
                    begin
                        stat_next = STAT_RANGE;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                MODE_POP:
                begin
                    if (empty)
                    begin
                        stat_next = STAT_EMPTY;
                    end
                    else
                    begin
                        fill_next = fill_reg - 1'b1;
                        if (side_reg == SIDE_FRONT)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (cmd.exec)
        begin
            q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            side_reg  <= in_side;
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
        stat_reg  <= stat_next;
        rd_ok_reg <= rd_ok_next;
        if (cmd.load)
        begin
            out_word_reg   <= rd_ok_reg ? q_reg : '0;
            out_status_reg <= stat_reg;
            out_count_reg  <= CNT_W'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    assign out_word   = out_word_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

    `RAD_ASSERT(a_fill_bound, fill_reg <= FILL_W'(DEPTH))
    `RAD_ASSERT_NEXT(a_push_grows, cmd.exec && mode_reg == MODE_PUSH && !full,
        fill_reg == $past(fill_reg) + 1'b1)
    `RAD_ASSERT_NEXT(a_state_holds, !cmd.exec, $stable(fill_reg) && $stable(head_reg))

endmodule

>>> rtl/core/random_access_deque_core.sv
// Random access deque core, top level: a deque of 32-bit words held in a
// circular store, with push and pop at either end and reads at any position.
// An accepted beat is captured into the input registers, executed against the
// single-port store in the next cycle, and its result beat is then loaded into
// the output register once that register is empty or being taken on m_tready;
// the next input beat is taken as soon as the result is loaded, even while that
// result still waits on m_tready. These steps follow from the store's single
// port and its registered read data. Pushes to a full store, pops from an empty
// one and reads past the count are reported in status and change nothing.
// Depends on rad_pkg, rad_ctrl and rad_datapath.
`timescale 1ns / 1ps

module random_access_deque_core
    import rad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value[31:0], position[41:32], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // mode[1:0], side[2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_word[31:0], status[33:32], count[44:34], zero pad
);

    rad_cmd_t          cmd;
    logic [WORD_W-1:0] out_word;
    logic [STAT_W-1:0] out_status;
    logic [CNT_W-1:0]  out_count;

    rad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rad_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_mode     (s_tuser[MODE_W-1:0]),
        .in_side     (s_tuser[MODE_W]),
        .in_value    (s_tdata[WORD_W-1:0]),
        .in_position (s_tdata[WORD_W+POS_W-1:WORD_W]),
        .out_word    (out_word),
        .out_status  (out_status),
        .out_count   (out_count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_status, out_word};

endmodule
